>>> sv/kv_request_byte_parser_macros.svh
// assertion macros for the kv request byte parser
// used by the top level; needs no other file
`ifndef KV_REQUEST_BYTE_PARSER_MACROS_SVH
`define KV_REQUEST_BYTE_PARSER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define KVBP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kvbp assertion failed");
// next-cycle implication, disabled during reset
`define KVBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kvbp assertion failed");
`else
`define KVBP_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define KVBP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/kvbp_pkg.sv
// shared types, constants and decimal accumulator helpers of the kv request parser
// no dependencies
package kvbp_pkg;

    localparam int LEN_BITS = 32;

    // character codes
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_FOUR  = 8'h34;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    // saturation limits of the magnitude accumulator
    localparam logic [63:0] MAG_LIMIT = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAG_DIV10 = 64'd922337203685477580;

    // element kinds
    localparam logic [1:0] KIND_STR  = 2'd0;
    localparam logic [1:0] KIND_ERR  = 2'd1;
    localparam logic [1:0] KIND_INT  = 2'd2;
    localparam logic [1:0] KIND_BULK = 2'd3;

    // protocol kinds
    localparam logic [1:0] PROTO_UNKNOWN = 2'd0;
    localparam logic [1:0] PROTO_RESP    = 2'd1;
    localparam logic [1:0] PROTO_BLOCK   = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE        = 5'd0,
        ST_STR         = 5'd1,
        ST_STR_CR      = 5'd2,
        ST_ERR         = 5'd3,
        ST_ERR_CR      = 5'd4,
        ST_NUM         = 5'd5,
        ST_NUM_CR      = 5'd6,
        ST_ARR         = 5'd7,
        ST_ARR_CR      = 5'd8,
        ST_BULK        = 5'd9,
        ST_BULK_CR     = 5'd10,
        ST_BDATA       = 5'd11,
        ST_BDATA_CR    = 5'd12,
        ST_BLK_NEXT    = 5'd13,
        ST_BLK_HDR     = 5'd14,
        ST_BLK_HDR_CR  = 5'd15,
        ST_BLK_DATA    = 5'd16,
        ST_BLK_DATA_CR = 5'd17,
        ST_HTTP_A      = 5'd18,
        ST_HTTP_B      = 5'd19,
        ST_HTTP_C      = 5'd20,
        ST_HTTP_D      = 5'd21
    } t_state;

    // streaming decimal accumulator
    typedef struct packed {
        logic [63:0] accum;
        logic        negative;
        logic        stopped;
        logic        started;
    } t_num;

    localparam t_num NUM_CLEAR = '{accum: 64'd0, negative: 1'b0, stopped: 1'b0,
                                   started: 1'b0};

    // one result transaction
    typedef struct packed {
        logic               payload_valid;
        logic [7:0]         payload_byte;
        logic               element_end;
        logic [1:0]         element_kind;
        logic signed [63:0] number_value;
        logic               command_end;
        logic [1:0]         protocol_kind;
        logic               http_request;
        logic               parse_error;
    } t_result;

    // feed one byte into the accumulator, strtoll style with saturation
    function automatic t_num num_feed(t_num cur, logic [7:0] c);
        t_num        r;
        logic [63:0] d;
        logic [63:0] v;
        r = cur;
        d = {56'd0, c - CH_0};
        v = (cur.accum << 3) + (cur.accum << 1) + d;
        if (!cur.stopped) begin
            if (c >= CH_0 && c <= CH_9) begin
                r.started = 1'b1;
                if (cur.accum > MAG_DIV10 || v > MAG_LIMIT) begin
                    r.accum = MAG_LIMIT;
                end else begin
                    r.accum = v;
                end
            end else if (!cur.started && (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
                r.started = 1'b0;
            end else if (!cur.started && (c == CH_PLUS || c == CH_MINUS)) begin
                r.started  = 1'b1;
                r.negative = (c == CH_MINUS);
            end else begin
                r.stopped = 1'b1;
            end
        end
        return r;
    endfunction

    // signed value of the accumulator
    function automatic logic [63:0] num_value(t_num cur);
        logic [63:0] r;
        if (cur.negative) begin
            r = 64'd0 - cur.accum;
        end else if (cur.accum >= MAG_LIMIT) begin
            r = MAG_LIMIT - 64'd1;
        end else begin
            r = cur.accum;
        end
        return r;
    endfunction

    // accumulator is a usable length: not negative and within LEN_BITS
    function automatic logic num_length_ok(t_num cur);
        logic r;
        r = !(cur.negative && cur.accum != 64'd0) && ((cur.accum >> LEN_BITS) == 64'd0);
        return r;
    endfunction

endpackage

>>> sv/kvbp_if.sv
// valid/ready channel interfaces of the kv request parser
// no dependencies
interface kvbp_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface kvbp_res_if;
    logic               valid;
    logic               ready;
    logic               payload_valid;
    logic [7:0]         payload_byte;
    logic               element_end;
    logic [1:0]         element_kind;
    logic signed [63:0] number_value;
    logic               command_end;
    logic [1:0]         protocol_kind;
    logic               http_request;
    logic               parse_error;

    modport source (output valid, output payload_valid, output payload_byte,
                    output element_end, output element_kind, output number_value,
                    output command_end, output protocol_kind, output http_request,
                    output parse_error, input ready);
    modport sink   (input valid, input payload_valid, input payload_byte,
                    input element_end, input element_kind, input number_value,
                    input command_end, input protocol_kind, input http_request,
                    input parse_error, output ready);
endinterface

>>> sv/kv_request_byte_parser.sv
// Byte-serial request parser for a key-value server.
// Input channel i_req carries one client byte per transaction (byte_in).
// Output channel o_res carries at most one result transaction per byte:
// payload bytes, element ends with kind and integer value, command ends,
// HTTP GET detection and parse errors; bytes with nothing to report
// produce no transaction.
// Path: a byte taken from i_req is held in the input register, parsed
// combinationally by kvbp_core and its result is registered in the result
// register that drives o_res.
// Throughput: one byte per cycle while the output is not stalled, set by the
// state update of the framing state machine and the decimal accumulator (a
// 64-bit x10 add and saturation compare).
// Reset (synchronous, active low) returns the parser to the start state,
// protocol unknown, with counters and accumulator cleared; no output is
// pending afterwards.
// When the receiver stalls, the result register holds its transaction; the
// input register still takes one more byte and then ready drops until the
// result is taken. Bytes that produce no result keep flowing only while the
// result register is not stalled.
// Depends on kvbp_pkg, kvbp_if, kvbp_core, kvbp_out_reg and the macro header.
`include "kv_request_byte_parser_macros.svh"
module kv_request_byte_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kvbp_req_if.sink   i_req,
    kvbp_res_if.source o_res
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              advance;
    logic              out_stall;
    logic              has_result;
    kvbp_pkg::t_result result;

    // parse the held byte whenever the result register can take its result
    assign advance     = r_in_valid && !out_stall;
    assign i_req.ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.valid && i_req.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_byte <= i_req.byte_in;
        end
    end

    // framing state machine
    kvbp_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (advance),
        .i_byte       (r_in_byte),
        .o_has_result (has_result),
        .o_result     (result)
    );

    // result register
    kvbp_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && has_result),
        .i_result (result),
        .o_stall  (out_stall),
        .o_res    (o_res)
    );

    // a parse error reports nothing else
    `KVBP_ASSERT_NOW(a_err_alone, i_clk, i_rst_n, o_res.valid && o_res.parse_error,
        !o_res.payload_valid && !o_res.element_end && !o_res.command_end &&
        !o_res.http_request)

    // kind and value only with an element end
    `KVBP_ASSERT_NOW(a_kind_with_end, i_clk, i_rst_n, o_res.valid && !o_res.element_end,
        o_res.element_kind == kvbp_pkg::KIND_STR && o_res.number_value == 64'sd0)

    // a parsed byte with a result shows up on the output next cycle
    `KVBP_ASSERT_NEXT(a_result_loaded, i_clk, i_rst_n, advance && has_result, o_res.valid)

    // input is only blocked by a full input register behind a stalled output
    `KVBP_ASSERT_NOW(a_ready_cause, i_clk, i_rst_n, !i_req.ready, r_in_valid && out_stall)

endmodule

>>> sv/kvbp_core.sv
// framing state machine and parse registers of the kv request parser
// depends on kvbp_pkg
module kvbp_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    output logic              o_has_result,
    output kvbp_pkg::t_result o_result
);

    kvbp_pkg::t_state                     r_state, n_state;
    logic [1:0]                           r_proto, n_proto;
    logic [kvbp_pkg::LEN_BITS-1:0]        r_items, n_items;
    logic [kvbp_pkg::LEN_BITS-1:0]        r_bytes, n_bytes;
    kvbp_pkg::t_num                       r_num, n_num;

    kvbp_pkg::t_num                       fed;
    logic                                 len_ok;
    logic [kvbp_pkg::LEN_BITS-1:0]        len;
    logic [kvbp_pkg::LEN_BITS-1:0]        items_dn;
    logic                                 pv, ee, ce, http, err;
    logic                                 blk_len, blk_elem, blk_ce;
    logic [1:0]                           kind;
    logic [63:0]                          num;

    // shared helpers for this byte
    assign fed      = kvbp_pkg::num_feed(r_num, i_byte);
    assign len_ok   = kvbp_pkg::num_length_ok(r_num);
    assign len      = r_num.accum[kvbp_pkg::LEN_BITS-1:0];
    assign items_dn = (r_items != '0) ? r_items - 1'b1 : r_items;

    // next state and flags
    always_comb begin
        n_state  = r_state;
        n_proto  = r_proto;
        n_items  = r_items;
        n_bytes  = r_bytes;
        n_num    = r_num;
        pv       = 1'b0;
        ee       = 1'b0;
        http     = 1'b0;
        err      = 1'b0;
        kind     = kvbp_pkg::KIND_STR;
        num      = 64'd0;
        blk_len  = 1'b0;
        blk_elem = 1'b0;
        blk_ce   = 1'b0;
        unique case (r_state) inside
            kvbp_pkg::ST_IDLE: begin
                n_proto = kvbp_pkg::PROTO_RESP;
                if (i_byte == kvbp_pkg::CH_PLUS) begin
                    n_state = kvbp_pkg::ST_STR;
                end else if (i_byte == kvbp_pkg::CH_MINUS) begin
                    n_state = kvbp_pkg::ST_ERR;
                end else if (i_byte == kvbp_pkg::CH_COLON) begin
                    n_state = kvbp_pkg::ST_NUM;
                end else if (i_byte == kvbp_pkg::CH_DOLLAR) begin
                    n_state = kvbp_pkg::ST_BULK;
                end else if (i_byte == kvbp_pkg::CH_STAR) begin
                    n_state = kvbp_pkg::ST_ARR;
                end else if (i_byte == kvbp_pkg::CH_FOUR) begin
                    n_state = kvbp_pkg::ST_BLK_HDR;
                    n_proto = kvbp_pkg::PROTO_BLOCK;
                    n_num   = fed;
                end else if (i_byte == kvbp_pkg::CH_G) begin
                    n_state = kvbp_pkg::ST_HTTP_A;
                    n_proto = r_proto;
                end else begin
                    n_state = kvbp_pkg::ST_STR;
                    pv      = 1'b1;
                end
            end
            kvbp_pkg::ST_STR: begin
                if (i_byte == kvbp_pkg::CH_CR) n_state = kvbp_pkg::ST_STR_CR;
                else pv = 1'b1;
            end
            kvbp_pkg::ST_ERR: begin
                if (i_byte == kvbp_pkg::CH_CR) n_state = kvbp_pkg::ST_ERR_CR;
                else pv = 1'b1;
            end
            kvbp_pkg::ST_NUM: begin
                if (i_byte == kvbp_pkg::CH_CR) n_state = kvbp_pkg::ST_NUM_CR;
                else n_num = fed;
            end
            kvbp_pkg::ST_ARR: begin
                if (i_byte == kvbp_pkg::CH_CR) n_state = kvbp_pkg::ST_ARR_CR;
                else n_num = fed;
            end
            kvbp_pkg::ST_BULK: begin
                if (i_byte == kvbp_pkg::CH_CR) n_state = kvbp_pkg::ST_BULK_CR;
                else n_num = fed;
            end
            kvbp_pkg::ST_STR_CR, kvbp_pkg::ST_ERR_CR, kvbp_pkg::ST_NUM_CR: begin
                if (i_byte != kvbp_pkg::CH_LF) begin
                    err = 1'b1;
                end else begin
                    ee = 1'b1;
                    if (r_state == kvbp_pkg::ST_ERR_CR) kind = kvbp_pkg::KIND_ERR;
                    if (r_state == kvbp_pkg::ST_NUM_CR) begin
                        kind = kvbp_pkg::KIND_INT;
                        num  = kvbp_pkg::num_value(r_num);
                    end
                    n_num   = kvbp_pkg::NUM_CLEAR;
                    n_items = items_dn;
                    n_state = kvbp_pkg::ST_IDLE;
                end
            end
            kvbp_pkg::ST_BULK_CR, kvbp_pkg::ST_ARR_CR: begin
                if (i_byte != kvbp_pkg::CH_LF || !len_ok) begin
                    err = 1'b1;
                end else begin
                    if (r_state == kvbp_pkg::ST_BULK_CR) begin
                        n_bytes = len;
                        n_state = kvbp_pkg::ST_BDATA;
                    end else begin
                        n_items = len;
                        n_state = kvbp_pkg::ST_IDLE;
                    end
                    n_num = kvbp_pkg::NUM_CLEAR;
                end
            end
            kvbp_pkg::ST_BDATA: begin
                if (r_bytes == '0) begin
                    if (i_byte == kvbp_pkg::CH_CR) n_state = kvbp_pkg::ST_BDATA_CR;
                    else err = 1'b1;
                end else begin
                    n_bytes = r_bytes - 1'b1;
                    pv      = 1'b1;
                end
            end
            kvbp_pkg::ST_BDATA_CR: begin
                if (i_byte != kvbp_pkg::CH_LF) begin
                    err = 1'b1;
                end else begin
                    ee      = 1'b1;
                    kind    = kvbp_pkg::KIND_BULK;
                    n_num   = kvbp_pkg::NUM_CLEAR;
                    n_items = items_dn;
                    n_state = kvbp_pkg::ST_IDLE;
                end
            end
            kvbp_pkg::ST_BLK_NEXT: begin
                if (i_byte == kvbp_pkg::CH_LF) begin
                    blk_ce = 1'b1;
                end else if (i_byte == kvbp_pkg::CH_CR) begin
                    n_state = kvbp_pkg::ST_BLK_HDR_CR;
                end else begin
                    n_state = kvbp_pkg::ST_BLK_HDR;
                    n_num   = fed;
                end
            end
            kvbp_pkg::ST_BLK_HDR: begin
                if (i_byte == kvbp_pkg::CH_CR) n_state = kvbp_pkg::ST_BLK_HDR_CR;
                else if (i_byte == kvbp_pkg::CH_LF) blk_len = 1'b1;
                else n_num = fed;
            end
            kvbp_pkg::ST_BLK_HDR_CR: begin
                if (i_byte == kvbp_pkg::CH_LF) blk_len = 1'b1;
                else err = 1'b1;
            end
            kvbp_pkg::ST_BLK_DATA: begin
                if (r_bytes == '0) begin
                    if (i_byte == kvbp_pkg::CH_CR) n_state = kvbp_pkg::ST_BLK_DATA_CR;
                    else if (i_byte == kvbp_pkg::CH_LF) blk_elem = 1'b1;
                    else err = 1'b1;
                end else begin
                    n_bytes = r_bytes - 1'b1;
                    pv      = 1'b1;
                end
            end
            kvbp_pkg::ST_BLK_DATA_CR: begin
                if (i_byte == kvbp_pkg::CH_LF) blk_elem = 1'b1;
                else err = 1'b1;
            end
            kvbp_pkg::ST_HTTP_A: begin
                if (i_byte == kvbp_pkg::CH_CR) n_state = kvbp_pkg::ST_HTTP_B;
            end
            kvbp_pkg::ST_HTTP_B: begin
                if (i_byte == kvbp_pkg::CH_LF) n_state = kvbp_pkg::ST_HTTP_C;
            end
            kvbp_pkg::ST_HTTP_C: begin
                if (i_byte == kvbp_pkg::CH_CR) n_state = kvbp_pkg::ST_HTTP_D;
            end
            kvbp_pkg::ST_HTTP_D: begin
                if (i_byte == kvbp_pkg::CH_LF) http = 1'b1;
            end
            default: begin
                // unused codes: a digit starts a block length
                if (i_byte >= kvbp_pkg::CH_0 && i_byte <= kvbp_pkg::CH_9) begin
                    n_state = kvbp_pkg::ST_BLK_HDR;
                    n_num   = fed;
                end else begin
                    err = 1'b1;
                end
            end
        endcase

        // block length line complete
        if (blk_len) begin
            if (!len_ok) begin
                err = 1'b1;
            end else begin
                n_bytes = len;
                n_num   = kvbp_pkg::NUM_CLEAR;
                n_state = kvbp_pkg::ST_BLK_DATA;
            end
        end

        // block data element complete
        if (blk_elem) begin
            ee      = 1'b1;
            kind    = kvbp_pkg::KIND_BULK;
            n_num   = kvbp_pkg::NUM_CLEAR;
            n_state = kvbp_pkg::ST_BLK_NEXT;
        end
    end

    // command end and result assembly
    assign ce = !err && (blk_ce || (n_state == kvbp_pkg::ST_IDLE && n_items == '0));
    assign o_has_result = pv || ee || ce || http || err;

    always_comb begin
        o_result.payload_valid = pv && !err;
        o_result.payload_byte  = (pv && !err) ? i_byte : 8'd0;
        o_result.element_end   = ee && !err;
        o_result.element_kind  = (ee && !err) ? kind : kvbp_pkg::KIND_STR;
        o_result.number_value  = err ? 64'sd0 : $signed(num);
        o_result.command_end   = ce;
        o_result.protocol_kind = err ? r_proto : n_proto;
        o_result.http_request  = http && !err;
        o_result.parse_error   = err;
    end

    // parse registers, left alone on a parse error
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kvbp_pkg::ST_IDLE;
            r_proto <= kvbp_pkg::PROTO_UNKNOWN;
            r_items <= '0;
            r_bytes <= '0;
            r_num   <= kvbp_pkg::NUM_CLEAR;
        end else if (i_step && !err) begin
            r_state <= n_state;
            r_proto <= n_proto;
            r_items <= n_items;
            r_bytes <= n_bytes;
            r_num   <= n_num;
        end
    end

endmodule

>>> sv/kvbp_out_reg.sv
// result register driving the output channel of the kv request parser
// depends on kvbp_pkg and kvbp_if
module kvbp_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  kvbp_pkg::t_result i_result,
    output logic              o_stall,
    kvbp_res_if.source        o_res
);

    logic              r_valid;
    kvbp_pkg::t_result r_result;

    // held result that the receiver has not taken yet
    assign o_stall = r_valid && !o_res.ready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_res.valid         = r_valid;
    assign o_res.payload_valid = r_result.payload_valid;
    assign o_res.payload_byte  = r_result.payload_byte;
    assign o_res.element_end   = r_result.element_end;
    assign o_res.element_kind  = r_result.element_kind;
    assign o_res.number_value  = r_result.number_value;
    assign o_res.command_end   = r_result.command_end;
    assign o_res.protocol_kind = r_result.protocol_kind;
    assign o_res.http_request  = r_result.http_request;
    assign o_res.parse_error   = r_result.parse_error;

endmodule
